@@ sv/ssas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssas_pkg
// Shared types and constants for the siren sweep and strobe core.
// ----------------------------------------------------------------------------
package ssas_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 10;
    localparam int DUTY_W        = 10;
    localparam int AUDIO_STEP_W  = 8;
    localparam int FREQ_W        = 11;
    localparam int STEP_W        = 7;
    localparam int SUM_W         = 13;
    localparam int ELAPSED_W     = 10;
    localparam int HALF_CNT_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_STEP_MS = 2'd1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MODE = 1'b1;

    typedef enum logic [2:0] {
        SIREN_OFF  = 3'd0,
        SIREN_WAIL = 3'd1,
        SIREN_YELP = 3'd2,
        SIREN_HILO = 3'd3,
        SIREN_WAR  = 3'd4,
        SIREN_HORN = 3'd5
    } t_mode;

    localparam logic [DUTY_W-1:0]       DUTY_RST       = 10'd800;
    localparam logic [AUDIO_STEP_W-1:0] AUDIO_STEP_RST = 8'd20;

    localparam logic [FREQ_W-1:0] FREQ_RST  = 11'd600;
    localparam logic [FREQ_W-1:0] FREQ_WAIL = 11'd600;
    localparam logic [FREQ_W-1:0] FREQ_YELP = 11'd700;
    localparam logic [FREQ_W-1:0] FREQ_LO   = 11'd700;
    localparam logic [FREQ_W-1:0] FREQ_HI   = 11'd1100;
    localparam logic [FREQ_W-1:0] FREQ_WAR  = 11'd300;
    localparam logic [FREQ_W-1:0] FREQ_HORN = 11'd420;

    localparam logic signed [STEP_W-1:0] STEP_RST     = 7'sd10;
    localparam logic signed [STEP_W-1:0] STEP_WAIL    = 7'sd12;
    localparam logic signed [STEP_W-1:0] STEP_YELP    = 7'sd40;
    localparam logic signed [STEP_W-1:0] STEP_NONE    = 7'sd0;
    localparam logic signed [STEP_W-1:0] STEP_WAR_UP  = 7'sd6;
    localparam logic signed [STEP_W-1:0] STEP_WAR_DN  = -7'sd4;

    localparam logic signed [SUM_W-1:0] WAIL_MAX = 13'sd1400;
    localparam logic signed [SUM_W-1:0] WAIL_MIN = 13'sd600;
    localparam logic signed [SUM_W-1:0] YELP_MAX = 13'sd1600;
    localparam logic signed [SUM_W-1:0] YELP_MIN = 13'sd700;
    localparam logic signed [SUM_W-1:0] WAR_MAX  = 13'sd900;
    localparam logic signed [SUM_W-1:0] WAR_MIN  = 13'sd300;

    localparam logic [HALF_CNT_W-1:0] HILO_HALF = 10'd500;
    localparam logic [HALF_CNT_W-1:0] HILO_LAST = 10'd999;

    localparam logic [ELAPSED_W-1:0] STROBE_WAIL  = 10'd400;
    localparam logic [ELAPSED_W-1:0] STROBE_WAR   = 10'd600;
    localparam logic [ELAPSED_W-1:0] STROBE_HORN  = 10'd80;
    localparam logic [ELAPSED_W-1:0] STROBE_OTHER = 10'd150;

    typedef struct packed {
        logic [DUTY_W-1:0]       strobe_duty;
        logic [AUDIO_STEP_W-1:0] audio_step_ms;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] led_right_duty;
        logic [DUTY_W-1:0] led_left_duty;
        logic [FREQ_W-1:0] tone_freq;
        logic              tone_on;
    } t_result;

endpackage

@@ sv/ssas_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssas_cfg
// Configuration register file: strobe duty and audio ramp interval.
// ----------------------------------------------------------------------------
module ssas_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssas_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssas_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ssas_pkg::t_cfg                   o_cfg
);
    import ssas_pkg::*;

    logic [DUTY_W-1:0]       r_duty;
    logic [AUDIO_STEP_W-1:0] r_audio_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= DUTY_RST;
            r_audio_step <= AUDIO_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STROBE_DUTY:   r_duty       <= i_cfg_data[DUTY_W-1:0];
                CFG_AUDIO_STEP_MS: r_audio_step <= i_cfg_data[AUDIO_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.strobe_duty   = r_duty;
    assign o_cfg.audio_step_ms = r_audio_step;

endmodule

@@ sv/ssas_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssas_engine
// Siren state and single-pass next-state logic: time count, frequency ramp,
// hi-lo half count and strobe timing.
// ----------------------------------------------------------------------------
module ssas_engine #(
    parameter int TIME_BITS = ssas_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_func,
    input  logic [2:0]        i_mode_sel,
    input  ssas_pkg::t_cfg    i_cfg,
    output ssas_pkg::t_result o_result
);
    import ssas_pkg::*;

    t_mode                     r_mode,     n_mode;
    logic [TIME_BITS-1:0]      r_time,     n_time;
    logic [HALF_CNT_W-1:0]     r_half,     n_half;
    logic [FREQ_W-1:0]         r_freq,     n_freq;
    logic signed [STEP_W-1:0]  r_step,     n_step;
    logic [ELAPSED_W-1:0]      r_aud_el,   n_aud_el;
    logic [ELAPSED_W-1:0]      r_str_el,   n_str_el;
    logic                      r_phase,    n_phase;
    logic                      r_lit,      n_lit;

    logic [ELAPSED_W-1:0]      aud_inc;
    logic [ELAPSED_W-1:0]      str_inc;
    logic [ELAPSED_W-1:0]      str_interval;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        unique case (r_mode)
            SIREN_WAIL: str_interval = STROBE_WAIL;
            SIREN_WAR:  str_interval = STROBE_WAR;
            SIREN_HORN: str_interval = STROBE_HORN;
            default:    str_interval = STROBE_OTHER;
        endcase
    end

    // saturating elapsed counters; only off mode lets them run far
    assign aud_inc = (&r_aud_el) ? r_aud_el : r_aud_el + 1'b1;
    assign str_inc = (&r_str_el) ? r_str_el : r_str_el + 1'b1;
    assign sum = signed'({2'b00, r_freq}) + SUM_W'(r_step);

    always_comb begin
        n_mode   = r_mode;
        n_time   = r_time;
        n_half   = r_half;
        n_freq   = r_freq;
        n_step   = r_step;
        n_aud_el = r_aud_el;
        n_str_el = r_str_el;
        n_phase  = r_phase;
        n_lit    = r_lit;
        if (i_func == FUNC_MODE) begin
            if (i_mode_sel <= 3'(SIREN_HORN)) begin
                n_mode   = t_mode'(i_mode_sel);
                n_aud_el = '0;
                n_str_el = '0;
                unique case (t_mode'(i_mode_sel))
                    SIREN_OFF:  n_lit = 1'b0;
                    SIREN_WAIL: begin
                        n_freq = FREQ_WAIL;
                        n_step = STEP_WAIL;
                    end
                    SIREN_YELP: begin
                        n_freq = FREQ_YELP;
                        n_step = STEP_YELP;
                    end
                    SIREN_HILO: begin
                        n_freq = FREQ_LO;
                        n_step = STEP_NONE;
                    end
                    SIREN_WAR: begin
                        n_freq = FREQ_WAR;
                        n_step = STEP_WAR_UP;
                    end
                    default: begin
                        n_freq = FREQ_HORN;
                        n_step = STEP_NONE;
                    end
                endcase
            end
        end else begin
            n_time   = r_time + 1'b1;
            // half count tracks time mod 1000 and restarts with the time wrap
            n_half   = ((&r_time) || (r_half == HILO_LAST)) ? '0 : r_half + 1'b1;
            n_aud_el = aud_inc;
            n_str_el = str_inc;
            if (r_mode != SIREN_OFF) begin
                if (aud_inc >= ELAPSED_W'(i_cfg.audio_step_ms)) begin
                    n_aud_el = '0;
                    unique case (r_mode)
                        SIREN_WAIL: begin
                            n_freq = sum[FREQ_W-1:0];
                            if (sum >= WAIL_MAX || sum <= WAIL_MIN) n_step = -r_step;
                        end
                        SIREN_YELP: begin
                            n_freq = sum[FREQ_W-1:0];
                            if (sum >= YELP_MAX || sum <= YELP_MIN) n_step = -r_step;
                        end
                        SIREN_HILO: n_freq = (n_half >= HILO_HALF) ? FREQ_HI : FREQ_LO;
                        SIREN_WAR: begin
                            n_freq = sum[FREQ_W-1:0];
                            if (sum >= WAR_MAX)      n_step = STEP_WAR_DN;
                            else if (sum <= WAR_MIN) n_step = STEP_WAR_UP;
                        end
                        default: ;
                    endcase
                end
                if (str_inc >= str_interval) begin
                    n_str_el = '0;
                    n_phase  = ~r_phase;
                    n_lit    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= SIREN_OFF;
            r_time   <= '0;
            r_half   <= '0;
            r_freq   <= FREQ_RST;
            r_step   <= STEP_RST;
            r_aud_el <= '0;
            r_str_el <= '0;
            r_phase  <= 1'b0;
            r_lit    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_time   <= n_time;
            r_half   <= n_half;
            r_freq   <= n_freq;
            r_step   <= n_step;
            r_aud_el <= n_aud_el;
            r_str_el <= n_str_el;
            r_phase  <= n_phase;
            r_lit    <= n_lit;
        end
    end

    assign o_result.tone_on        = (n_mode != SIREN_OFF);
    assign o_result.tone_freq      = n_freq;
    assign o_result.led_left_duty  = (n_lit && n_phase)  ? i_cfg.strobe_duty : '0;
    assign o_result.led_right_duty = (n_lit && !n_phase) ? i_cfg.strobe_duty : '0;

`ifndef SYNTH
    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half <= HILO_LAST)
        else $error("hi-lo half count out of range");

    a_strobe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != SIREN_OFF) |-> (r_str_el <= STROBE_WAR))
        else $error("strobe elapsed count overran its interval");

    a_audio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != SIREN_OFF) |-> (r_aud_el <= ELAPSED_W'(8'hFF)))
        else $error("audio elapsed count overran its interval");

    a_off_holds_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_func == FUNC_TICK && r_mode == SIREN_OFF) |=> $stable(r_freq))
        else $error("frequency moved while off");
`endif

endmodule

@@ sv/ssas_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssas_out_stage
// Result register between the next-state logic and the master stream.
// ----------------------------------------------------------------------------
module ssas_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ssas_pkg::t_result i_result,
    input  logic              i_take,
    output logic              o_room,
    output logic              o_valid,
    output ssas_pkg::t_result o_result
);
    import ssas_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_room = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |-> !i_load)
        else $error("result overwritten before transfer");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_result)))
        else $error("stalled result changed");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");
`endif

endmodule

@@ sv/siren_sweep_and_strobe_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siren_sweep_and_strobe_core
// Siren tone sweep and left/right strobe controller, one result per item.
// ----------------------------------------------------------------------------
// Each input transfer is a 1 ms tick (tuser 0) or a mode change (tuser 1,
// mode in tdata[2:0]: off, wail, yelp, hi-lo, war, horn; codes 6 and 7 are
// ignored). Every transfer yields exactly one result in the cycle after it, taken
// from a single next-state pass over the state registers; a new item is
// accepted every cycle, and s_axis_tready falls only while the result
// register is full and the downstream side stalls. No clearing pass after
// reset. Result tdata: tone_on [0], tone_freq [11:1], led_left_duty [21:12],
// led_right_duty [31:22].
// ----------------------------------------------------------------------------
module siren_sweep_and_strobe_core #(
    parameter int TIME_BITS = ssas_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // mode select [2:0], zeros
    input  logic                            s_axis_tuser,  // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tone_on, tone_freq, led_left_duty, led_right_duty
    output logic [31:0]                     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssas_pkg::*;

    t_cfg    cfg;
    t_result next_result;
    t_result out_result;
    logic    room;
    logic    in_xfer;
    logic    out_xfer;

    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid && room;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    ssas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssas_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_func     (s_axis_tuser),
        .i_mode_sel (s_axis_tdata[2:0]),
        .i_cfg      (cfg),
        .o_result   (next_result)
    );

    ssas_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_xfer),
        .i_result (next_result),
        .i_take   (out_xfer),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {out_result.led_right_duty, out_result.led_left_duty,
                           out_result.tone_freq, out_result.tone_on};

endmodule
